FILE: rtl/core/alrg_pkg.sv
// Shared types, constants and helper functions for the additive lagged generator.
`default_nettype none

package alrg_pkg;

	localparam int unsigned LAG_DEPTH = 55;
	localparam int unsigned IDX_W = $clog2(LAG_DEPTH);
	localparam int unsigned WORD_W = 32;
	localparam int unsigned TRAIL_OFFSET = 20;
	localparam int unsigned SEED_MUL_PREV = 1001;
	localparam int unsigned SEED_MUL_SEED = 999;
	localparam int unsigned DIV_STEPS = WORD_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	// 2^20 is 1 modulo 55, so the two chunks of a word split at bit 20 can be summed
	// before the reduction. The sum is then divided by 55 through a multiply by
	// ceil(2^27 / 55), which is exact for every 21-bit value.
	localparam int unsigned FOLD_SPLIT = 20;
	localparam int unsigned FOLD_W = FOLD_SPLIT + 1;
	localparam int unsigned MOD_RECIP = 2440323;
	localparam int unsigned RECIP_W = 22;
	localparam int unsigned MOD_SHIFT = 27;
	localparam int unsigned PROD_W = FOLD_W + RECIP_W;
	localparam int unsigned QUOT_W = PROD_W - MOD_SHIFT;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [DIV_CNT_W-1:0] div_cnt_t;

	typedef enum logic [1:0] {
		OP_SEED    = 2'd0,
		OP_DRAW    = 2'd1,
		OP_BOUNDED = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED_RD,
		ST_SEED_WR,
		ST_DRAW_RA,
		ST_DRAW_RB,
		ST_DRAW_SUM,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic  wr_en;
		idx_t  wr_addr;
		word_t wr_data;
		idx_t  rd_addr;
	} tbl_req_t;

	typedef struct packed {
		logic  start;
		word_t dividend;
		word_t divisor;
	} div_req_t;

	typedef struct packed {
		logic  done;
		word_t rem;
	} div_rsp_t;

	localparam idx_t LAST_IDX = idx_t'(LAG_DEPTH - 1);

	function automatic idx_t wrap_next(input idx_t idx);
		return (idx == LAST_IDX) ? '0 : idx + idx_t'(1);
	endfunction

	function automatic idx_t trail_from_lead(input idx_t lead);
		logic [IDX_W:0] tmp;
		tmp = {1'b0, lead} + (IDX_W + 1)'(TRAIL_OFFSET);
		if (tmp >= (IDX_W + 1)'(LAG_DEPTH)) begin
			tmp = tmp - (IDX_W + 1)'(LAG_DEPTH);
		end
		return tmp[IDX_W-1:0];
	endfunction

	// Power-up contents of the lag table.
	function automatic word_t lag_init(input idx_t idx);
		word_t v;
		case (idx)
			6'd0:  v = 32'o35340171546;
			6'd1:  v = 32'o10401501101;
			6'd2:  v = 32'o22364657325;
			6'd3:  v = 32'o24130436022;
			6'd4:  v = 32'o2167303062;
			6'd5:  v = 32'o37570375137;
			6'd6:  v = 32'o37210607110;
			6'd7:  v = 32'o16272055420;
			6'd8:  v = 32'o23011770546;
			6'd9:  v = 32'o17143426366;
			6'd10: v = 32'o14753657433;
			6'd11: v = 32'o21657231332;
			6'd12: v = 32'o23553406142;
			6'd13: v = 32'o4236526362;
			6'd14: v = 32'o10365611275;
			6'd15: v = 32'o7117336710;
			6'd16: v = 32'o11051276551;
			6'd17: v = 32'o2362132524;
			6'd18: v = 32'o1011540233;
			6'd19: v = 32'o12162531646;
			6'd20: v = 32'o7056762337;
			6'd21: v = 32'o6631245521;
			6'd22: v = 32'o14164542224;
			6'd23: v = 32'o32633236305;
			6'd24: v = 32'o23342700176;
			6'd25: v = 32'o2433062234;
			6'd26: v = 32'o15257225043;
			6'd27: v = 32'o26762051606;
			6'd28: v = 32'o742573230;
			6'd29: v = 32'o5366042132;
			6'd30: v = 32'o12126416411;
			6'd31: v = 32'o520471171;
			6'd32: v = 32'o725646277;
			6'd33: v = 32'o20116577576;
			6'd34: v = 32'o25765742604;
			6'd35: v = 32'o7633473735;
			6'd36: v = 32'o15674255275;
			6'd37: v = 32'o17555634041;
			6'd38: v = 32'o6503154145;
			6'd39: v = 32'o21576344247;
			6'd40: v = 32'o14577627653;
			6'd41: v = 32'o2707523333;
			6'd42: v = 32'o34146376720;
			6'd43: v = 32'o30060227734;
			6'd44: v = 32'o13765414060;
			6'd45: v = 32'o36072251540;
			6'd46: v = 32'o7255221037;
			6'd47: v = 32'o24364674123;
			6'd48: v = 32'o6200353166;
			6'd49: v = 32'o10126373326;
			6'd50: v = 32'o15664104320;
			6'd51: v = 32'o16401041535;
			6'd52: v = 32'o16215305520;
			6'd53: v = 32'o33115351014;
			6'd54: v = 32'o17411670323;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/alrg_table.sv
// Lag table memory with per-entry valid bits that fall back to the power-up constants.
`default_nettype none

module alrg_table (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire alrg_pkg::tbl_req_t req,
	output      alrg_pkg::word_t    rdata
);
	import alrg_pkg::*;

	word_t                 mem [LAG_DEPTH];
	logic [LAG_DEPTH-1:0]  valid_q;
	word_t                 mem_rd_q;
	word_t                 init_rd_q;
	logic                  sel_rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		mem_rd_q  <= mem[req.rd_addr];
		init_rd_q <= lag_init(req.rd_addr);
		sel_rd_q  <= valid_q[req.rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	// An entry never written since reset still holds its power-up constant.
	assign rdata = sel_rd_q ? mem_rd_q : init_rd_q;

endmodule

`default_nettype wire

FILE: rtl/core/alrg_divider.sv
// Restoring remainder unit, one quotient bit per cycle.
`default_nettype none

module alrg_divider (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire alrg_pkg::div_req_t req,
	output      alrg_pkg::div_rsp_t rsp
);
	import alrg_pkg::*;

	logic     busy_q;
	logic     done_q;
	div_cnt_t cnt_q;
	word_t    rem_q;
	word_t    dvd_q;
	word_t    dsr_q;

	logic [WORD_W:0]   trial;
	logic [WORD_W+1:0] diff;

	assign trial = {rem_q, dvd_q[WORD_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + div_cnt_t'(1);
				if (cnt_q == div_cnt_t'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
			// The partial remainder stays below the divisor, so it fits one word.
			if (diff[WORD_W+1]) begin
				rem_q <= trial[WORD_W-1:0];
			end else begin
				rem_q <= diff[WORD_W-1:0];
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

FILE: rtl/core/alrg_ctrl.sv
// Sequencer and datapath for seeding and drawing from the lag table.
`default_nettype none

module alrg_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [1:0]         operation,
	input  wire alrg_pkg::word_t    bound,
	output      logic               busy,
	output      alrg_pkg::word_t    value,
	output      logic               done,
	input  wire logic               cfg_valid,
	input  wire alrg_pkg::word_t    seed_value,
	output      alrg_pkg::tbl_req_t tbl_req,
	input  wire alrg_pkg::word_t    tbl_rdata,
	output      alrg_pkg::div_req_t div_req,
	input  wire alrg_pkg::div_rsp_t div_rsp
);
	import alrg_pkg::*;

	ctrl_state_t state_q, state_d;
	idx_t        lead_q;
	idx_t        trail_q;
	idx_t        idx_q;
	word_t       seed_q;
	logic        done_q;

	op_t   op_q;
	word_t bound_q;
	word_t p1_q;
	word_t p2_q;
	word_t mix_q;
	word_t prev_q;
	word_t lead_val_q;
	word_t div_a_q;
	word_t div_b_q;
	word_t value_q;
	word_t entry0_q;

	logic [QUOT_W-1:0] mod_quot_q;

	word_t mix_next;
	word_t seed_entry;
	word_t draw_sum;
	logic  need_mod;

	logic [FOLD_W-1:0] fold_sum;
	logic [PROD_W-1:0] fold_prod;
	logic [FOLD_W-1:0] fold_rem;
	idx_t              seed_lead;

	assign mix_next   = p1_q + p2_q;
	assign seed_entry = tbl_rdata + mix_next;
	assign draw_sum   = lead_val_q + tbl_rdata;
	assign need_mod   = (op_q == OP_BOUNDED) && (bound_q != '0);

	// Entry 0 is final once the walk has passed it, so its reduction modulo 55
	// settles in the background long before the walk ends.
	assign fold_sum  = FOLD_W'(entry0_q[WORD_W-1:FOLD_SPLIT]) + FOLD_W'(entry0_q[FOLD_SPLIT-1:0]);
	assign fold_prod = PROD_W'(fold_sum) * PROD_W'(MOD_RECIP);
	assign fold_rem  = fold_sum - FOLD_W'(mod_quot_q) * FOLD_W'(LAG_DEPTH);
	assign seed_lead = fold_rem[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		tbl_req.wr_en    = 1'b0;
		tbl_req.wr_addr  = idx_q;
		tbl_req.wr_data  = seed_entry;
		tbl_req.rd_addr  = idx_q;
		div_req.start    = 1'b0;
		div_req.dividend = div_a_q;
		div_req.divisor  = div_b_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (operation) inside
						OP_SEED:             state_d = ST_SEED_RD;
						OP_DRAW, OP_BOUNDED: state_d = ST_DRAW_RA;
						default:             state_d = ST_FINISH;
					endcase
				end
			end
			ST_SEED_RD: begin
				state_d = ST_SEED_WR;
			end
			ST_SEED_WR: begin
				tbl_req.wr_en = 1'b1;
				state_d = (idx_q == LAST_IDX) ? ST_IDLE : ST_SEED_RD;
			end
			ST_DRAW_RA: begin
				tbl_req.rd_addr = lead_q;
				state_d = ST_DRAW_RB;
			end
			ST_DRAW_RB: begin
				tbl_req.rd_addr = trail_q;
				state_d = ST_DRAW_SUM;
			end
			ST_DRAW_SUM: begin
				tbl_req.wr_en   = 1'b1;
				tbl_req.wr_addr = lead_q;
				tbl_req.wr_data = draw_sum;
				state_d = need_mod ? ST_DIV_START : ST_IDLE;
			end
			ST_DIV_START: begin
				div_req.start = 1'b1;
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_IDLE;
				end
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q  <= '0;
			trail_q <= idx_t'(TRAIL_OFFSET);
			idx_q   <= '0;
			seed_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				seed_q <= seed_value;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
				end
				ST_SEED_WR: begin
					idx_q <= wrap_next(idx_q);
					if (idx_q == LAST_IDX) begin
						done_q  <= 1'b1;
						lead_q  <= seed_lead;
						trail_q <= trail_from_lead(seed_lead);
					end
				end
				ST_DRAW_SUM: begin
					lead_q  <= wrap_next(lead_q);
					trail_q <= wrap_next(trail_q);
					if (!need_mod) begin
						done_q <= 1'b1;
					end
				end
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						done_q <= 1'b1;
					end
				end
				ST_FINISH: begin
					done_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mod_quot_q <= fold_prod[PROD_W-1:MOD_SHIFT];
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_q    <= op_t'(operation);
					bound_q <= bound;
				end
			end
			ST_SEED_RD: begin
				// Entry 0 adds the seed itself to its old value; later entries add the running mix.
				if (idx_q == '0) begin
					p1_q <= seed_q;
					p2_q <= '0;
				end else begin
					p1_q <= prev_q * word_t'(SEED_MUL_PREV);
					p2_q <= mix_q * word_t'(SEED_MUL_SEED);
				end
			end
			ST_SEED_WR: begin
				mix_q  <= mix_next;
				prev_q <= seed_entry;
				if (idx_q == '0) begin
					entry0_q <= seed_entry;
				end
				if (idx_q == LAST_IDX) begin
					value_q <= '0;
				end
			end
			ST_DRAW_RB: begin
				lead_val_q <= tbl_rdata;
			end
			ST_DRAW_SUM: begin
				value_q <= draw_sum;
				div_a_q <= draw_sum;
				div_b_q <= bound_q;
			end
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					value_q <= div_rsp.rem;
				end
			end
			ST_FINISH: begin
				value_q <= '0;
			end
			default: begin
			end
		endcase
	end

	assign value = value_q;
	assign done  = done_q;

endmodule

`default_nettype wire

FILE: rtl/core/additive_lagged_random_generator.sv
// Top level of the additive lagged random generator.
// A request is taken when start is high and busy is low; busy then stays high until the
// result appears on value for exactly one cycle with done high, and it must be captured
// in that cycle because the block cannot be held off. A raw draw goes from the request
// to done through two reads of the single-read-port lag table, then the sum. A bounded
// draw with a nonzero bound then runs the bit-serial remainder unit. A seed request
// walks all 55 table entries, each with a read, then a multiply-add and write back;
// entry 0 is reduced modulo 55 while the walk goes on, so the result follows the walk
// directly. An unused operation code returns zero. The seed register is written
// through cfg_valid and seed_value, which is always ready; write it only while the
// block is idle.
`default_nettype none

module additive_lagged_random_generator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic [1:0]  operation,
	input  wire logic [31:0] bound,
	output      logic        done,
	output      logic [31:0] value,
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [31:0] seed_value
);
	import alrg_pkg::*;

	tbl_req_t tbl_req;
	word_t    tbl_rdata;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign cfg_ready = 1'b1;

	alrg_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tbl_req),
		.rdata  (tbl_rdata)
	);

	alrg_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	alrg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.operation  (operation),
		.bound      (bound),
		.busy       (busy),
		.value      (value),
		.done       (done),
		.cfg_valid  (cfg_valid),
		.seed_value (seed_value),
		.tbl_req    (tbl_req),
		.tbl_rdata  (tbl_rdata),
		.div_req    (div_req),
		.div_rsp    (div_rsp)
	);

endmodule

`default_nettype wire

FILE: rtl/core/alrg_checker.sv
// Port-level assertions for the generator, bound to the top level.
`default_nettype none

module alrg_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	// An accepted request always occupies the block.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	// Finishing a request always delivers its result.
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// A result only appears when the block has finished.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result appeared without a request in flight");

	// Each request yields a single result.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result repeated");

endmodule

bind additive_lagged_random_generator alrg_checker u_alrg_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire
